@@ rtl/core/ansi_text_terminal_assert.svh @@
// ----------------------------------------------------------------------------
// ansi_text_terminal assertion macros
// Property wrappers used by the port-level checker of the text terminal.
// ----------------------------------------------------------------------------
`ifndef ANSI_TEXT_TERMINAL_ASSERT_SVH
`define ANSI_TEXT_TERMINAL_ASSERT_SVH

// same-cycle implication
`define ATT_ASSERT_IMP(name, clk, rst, a, c) \
   name: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("ansi_text_terminal: check failed");

// next-cycle implication
`define ATT_ASSERT_NEXT(name, clk, rst, a, c) \
   name: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("ansi_text_terminal: check failed");

`endif

@@ rtl/core/att_pkg.sv @@
// ----------------------------------------------------------------------------
// att_pkg
// Constants, byte codes, command codes and word types of the text terminal.
// ----------------------------------------------------------------------------
`default_nettype none
package att_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int TAB_STOP   = 8;
   localparam int MAX_ESCAPE = 16;

   localparam int COL_W     = $clog2(COLUMNS);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int TAB_W     = $clog2(TAB_STOP + 1);
   localparam int ESC_W     = $clog2(MAX_ESCAPE + 1);
   localparam int IDX_W     = $clog2(MAX_ESCAPE);
   localparam int RAM_AW    = ROW_W + COL_W;
   localparam int RAM_DEPTH = ROWS * (1 << COL_W);
   localparam int CELL_W    = 16;
   localparam int CQ_DEPTH  = 4;
   localparam int CQ_AW     = 2;

   localparam logic [7:0] BYTE_ESC   = 8'h1B;
   localparam logic [7:0] BYTE_LBRK  = 8'h5B;
   localparam logic [7:0] BYTE_M     = 8'h6D;
   localparam logic [7:0] BYTE_J     = 8'h4A;
   localparam logic [7:0] BYTE_TWO   = 8'h32;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_NL    = 8'h0A;
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_SEMI  = 8'h3B;
   localparam logic [7:0] BYTE_ZERO  = 8'h30;
   localparam logic [7:0] BYTE_NINE  = 8'h39;

   localparam logic [3:0] FG_RESET = 4'hF;
   localparam logic [3:0] BG_RESET = 4'h0;

   localparam logic [2:0] CMD_PUT     = 3'd0;
   localparam logic [2:0] CMD_NEWLINE = 3'd1;
   localparam logic [2:0] CMD_TAB     = 3'd2;
   localparam logic [2:0] CMD_CLEAR   = 3'd3;
   localparam logic [2:0] CMD_COLOR   = 3'd4;
   localparam logic [2:0] CMD_READ    = 3'd5;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic [3:0] fg;
      logic [3:0] bg;
      logic [4:0] row;
      logic [6:0] col;
   } cmd_type;

   typedef struct packed {
      logic [7:0] ch;
      logic [3:0] fg;
      logic [3:0] bg;
      logic [4:0] row;
      logic [6:0] col;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/core/ansi_text_terminal.sv @@
// ----------------------------------------------------------------------------
// ansi_text_terminal
// Character-cell text screen fed by a byte stream with ANSI clear and color
// sequences; cells and cursor are read back through the result queue.
//
//   channel   handshake        word
//   request   push / full      operation, text_byte, read_row, read_column
//   response  pop / empty      cell, colors, cursor position
//
// A printable byte becomes a put command that writes one cell; a tab writes
// spaces up to the next tab stop, a scroll blanks the COLUMNS cells of a row,
// a clear sweeps all ROWS*128 (3200) cells, a literal replay issues one put
// per byte, and a read is registered. The single write port of the cell
// memory sets the pace. After reset a clearing pass holds full high.
// The command queue lets the decoder run ahead of long scrolls and clears.
// ----------------------------------------------------------------------------
`default_nettype none
module ansi_text_terminal
   import att_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic       req_operation,
   input  wire logic [7:0] req_text_byte,
   input  wire logic [4:0] req_read_row,
   input  wire logic [6:0] req_read_column,
   output logic            empty,
   input  wire logic       pop,
   output logic [7:0]      rsp_cell_character,
   output logic [3:0]      rsp_cell_foreground,
   output logic [3:0]      rsp_cell_background,
   output logic [4:0]      rsp_cursor_row_out,
   output logic [6:0]      rsp_cursor_column_out
);

   cmd_type fe_cmd, q_cmd;
   logic    fe_push, q_full, q_pop, q_valid, be_busy;
   rsp_type rsp;

   att_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .operation(req_operation), .text_byte(req_text_byte),
      .read_row(req_read_row), .read_column(req_read_column),
      .back_busy(be_busy), .cmd_full(q_full), .cmd_push(fe_push), .cmd(fe_cmd)
   );

   att_cmdq u_cmdq (
      .clock(clock), .reset(reset), .push(fe_push), .din(fe_cmd), .full(q_full),
      .pop(q_pop), .dout(q_cmd), .valid(q_valid)
   );

   att_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(q_valid), .cmd(q_cmd),
      .cmd_pop(q_pop), .busy(be_busy), .empty(empty), .pop(pop), .rsp(rsp)
   );

   assign rsp_cell_character    = rsp.ch;
   assign rsp_cell_foreground   = rsp.fg;
   assign rsp_cell_background   = rsp.bg;
   assign rsp_cursor_row_out    = rsp.row;
   assign rsp_cursor_column_out = rsp.col;

endmodule
`default_nettype wire

@@ rtl/core/att_ram.sv @@
// ----------------------------------------------------------------------------
// att_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module att_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

@@ rtl/core/att_cmdq.sv @@
// ----------------------------------------------------------------------------
// att_cmdq
// Short command queue between the byte decoder and the screen engine.
// ----------------------------------------------------------------------------
`default_nettype none
module att_cmdq
   import att_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type din,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      dout,
   output logic         valid
);

   cmd_type          q_ff [CQ_DEPTH];
   logic [CQ_AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CQ_AW:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == (CQ_AW+1)'(CQ_DEPTH));
   assign valid = (cnt_ff != '0);
   assign dout  = q_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = rp_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= din;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/att_front.sv @@
// ----------------------------------------------------------------------------
// att_front
// Byte decoder: classifies words, parses escape sequences, replays invalid
// sequences as literal characters and issues screen commands.
// ----------------------------------------------------------------------------
`default_nettype none
module att_front
   import att_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic       operation,
   input  wire logic [7:0] text_byte,
   input  wire logic [4:0] read_row,
   input  wire logic [6:0] read_column,
   input  wire logic       back_busy,
   input  wire logic       cmd_full,
   output logic            cmd_push,
   output cmd_type         cmd
);

   localparam logic F_IDLE   = 1'b0;
   localparam logic F_REPLAY = 1'b1;

   typedef struct packed {
      logic       fail;
      logic       bold;
      logic [3:0] fg;
      logic [3:0] bg;
   } color_type;

   function automatic color_type color_eval(color_type c, logic [9:0] v);
      color_type r;
      r = c;
      if (!c.fail) begin
         if (v == 10'd0) begin
            r.bold = 1'b0;
         end else if (v == 10'd1) begin
            r.bold = 1'b1;
         end else if (v >= 10'd30 && v <= 10'd37) begin
            r.fg = {c.bold, 3'(v - 10'd30)};
         end else if (v >= 10'd40 && v <= 10'd47) begin
            r.bg = {c.bold, 3'(v - 10'd40)};
         end else begin
            r.fail = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic [9:0] digit_step(logic [9:0] v, logic [7:0] b);
      logic [13:0] t;
      t = {v, 3'b000} + {v, 1'b0} + 14'(b - BYTE_ZERO);
      return (t > 14'd1000) ? 10'd1000 : t[9:0];
   endfunction

   function automatic cmd_type plain_cmd(logic [7:0] b);
      cmd_type c;
      c      = '0;
      c.data = b;
      if (b == BYTE_NL) begin
         c.kind = CMD_NEWLINE;
      end else if (b == BYTE_TAB) begin
         c.kind = CMD_TAB;
      end else begin
         c.kind = CMD_PUT;
      end
      return c;
   endfunction

   logic             state_ff, state_in;
   logic [ESC_W-1:0] len_ff, len_in, n_ff, n_in, k_ff, k_in, newlen;
   logic [7:0]       buf_ff [MAX_ESCAPE];
   logic [9:0]       val_ff, val_in;
   color_type        pend_ff, pend_in, fin;
   logic             digit_ff, digit_in, two_ff, two_in;
   logic [3:0]       fg_ff, fg_in, bg_ff, bg_in;
   logic             accept, buf_we, is_digit, overlong;
   logic [7:0]       last;

   assign full     = (state_ff != F_IDLE) || cmd_full || back_busy;
   assign accept   = push && !full;
   assign newlen   = len_ff + 1'b1;
   assign is_digit = (text_byte >= BYTE_ZERO) && (text_byte <= BYTE_NINE);
   assign overlong = (newlen >= ESC_W'(MAX_ESCAPE));
   assign last     = buf_ff[k_ff[IDX_W-1:0]];
   assign fin      = digit_ff ? color_eval(pend_ff, val_ff) : pend_ff;

   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      val_in   = val_ff;
      pend_in  = pend_ff;
      digit_in = digit_ff;
      two_in   = two_ff;
      fg_in    = fg_ff;
      bg_in    = bg_ff;
      cmd_push = 1'b0;
      cmd      = '0;
      buf_we   = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               if (operation) begin
                  cmd_push = 1'b1;
                  cmd.kind = CMD_READ;
                  cmd.row  = read_row;
                  cmd.col  = read_column;
               end else if (len_ff == '0) begin
                  if (text_byte == BYTE_ESC) begin
                     len_in   = ESC_W'(1);
                     pend_in  = {1'b0, 1'b0, fg_ff, bg_ff};
                     val_in   = '0;
                     digit_in = 1'b0;
                  end else begin
                     cmd_push = 1'b1;
                     cmd      = plain_cmd(text_byte);
                  end
               end else begin
                  buf_we = 1'b1;
                  n_in   = newlen;
                  k_in   = '0;
                  if (newlen == ESC_W'(2)) begin
                     if (text_byte == BYTE_LBRK) begin
                        len_in = newlen;
                     end else begin
                        state_in = F_REPLAY;
                        len_in   = '0;
                     end
                  end else if (is_digit || text_byte == BYTE_SEMI) begin
                     if (is_digit) begin
                        val_in   = digit_step(val_ff, text_byte);
                        digit_in = 1'b1;
                     end else begin
                        pend_in  = color_eval(pend_ff, val_ff);
                        val_in   = '0;
                        digit_in = 1'b0;
                     end
                     if (newlen == ESC_W'(3)) begin
                        two_in = (text_byte == BYTE_TWO);
                     end
                     if (overlong) begin
                        state_in = F_REPLAY;
                        len_in   = '0;
                     end else begin
                        len_in = newlen;
                     end
                  end else if (text_byte == BYTE_J) begin
                     len_in = '0;
                     if (newlen == ESC_W'(4) && two_ff) begin
                        cmd_push = 1'b1;
                        cmd.kind = CMD_CLEAR;
                     end else begin
                        state_in = F_REPLAY;
                     end
                  end else if (text_byte == BYTE_M) begin
                     len_in = '0;
                     if (newlen > ESC_W'(3)) begin
                        cmd_push = 1'b1;
                        cmd.kind = CMD_COLOR;
                        cmd.fg   = fin.fg;
                        cmd.bg   = fin.bg;
                        fg_in    = fin.fg;
                        bg_in    = fin.bg;
                        if (fin.fail) begin
                           state_in = F_REPLAY;
                        end
                     end else begin
                        state_in = F_REPLAY;
                     end
                  end else begin
                     len_in   = '0;
                     state_in = F_REPLAY;
                  end
               end
            end
         end
         F_REPLAY: begin
            if (!cmd_full) begin
               if (k_ff == '0) begin
                  cmd_push = 1'b1;
                  cmd.kind = CMD_PUT;
                  cmd.data = BYTE_ESC;
                  k_in     = k_ff + 1'b1;
               end else if (k_ff != n_ff - 1'b1) begin
                  cmd_push = 1'b1;
                  cmd.kind = CMD_PUT;
                  cmd.data = last;
                  k_in     = k_ff + 1'b1;
               end else begin
                  state_in = F_IDLE;
                  if (last == BYTE_ESC) begin
                     len_in   = ESC_W'(1);
                     pend_in  = {1'b0, 1'b0, fg_ff, bg_ff};
                     val_in   = '0;
                     digit_in = 1'b0;
                  end else begin
                     cmd_push = 1'b1;
                     cmd      = plain_cmd(last);
                  end
               end
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         len_ff   <= '0;
         fg_ff    <= FG_RESET;
         bg_ff    <= BG_RESET;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         fg_ff    <= fg_in;
         bg_ff    <= bg_in;
      end
      n_ff     <= n_in;
      k_ff     <= k_in;
      val_ff   <= val_in;
      pend_ff  <= pend_in;
      digit_ff <= digit_in;
      two_ff   <= two_in;
      if (buf_we) begin
         buf_ff[len_ff[IDX_W-1:0]] <= text_byte;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/att_back.sv @@
// ----------------------------------------------------------------------------
// att_back
// Screen engine: cursor, colors, cell memory with a rotating top row,
// scroll and clear sweeps, cell reads and the result queue.
// ----------------------------------------------------------------------------
`default_nettype none
module att_back
   import att_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd,
   output logic         cmd_pop,
   output logic         busy,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp
);

   localparam logic [2:0] B_IDLE   = 3'd0;
   localparam logic [2:0] B_SCROLL = 3'd1;
   localparam logic [2:0] B_TAB    = 3'd2;
   localparam logic [2:0] B_CLEAR  = 3'd3;
   localparam logic [2:0] B_READ   = 3'd4;

   function automatic logic [ROW_W-1:0] phys_row(logic [ROW_W-1:0] top,
                                                 logic [ROW_W-1:0] r);
      logic [ROW_W:0] s;
      s = {1'b0, top} + {1'b0, r};
      if (s >= (ROW_W+1)'(ROWS)) begin
         s = s - (ROW_W+1)'(ROWS);
      end
      return s[ROW_W-1:0];
   endfunction

   logic [2:0]        state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in, top_ff, top_in, srow_ff, srow_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [TAB_W-1:0]  tab_ff, tab_in, tab_nx;
   logic [3:0]        fg_ff, fg_in, bg_ff, bg_in;
   logic [RAM_AW-1:0] sweep_ff, sweep_in;
   logic              init_ff, init_in, oob_ff, oob_in;
   rsp_type           oq_ff [2];
   logic              oq_wp_ff, oq_rp_ff;
   logic [1:0]        oq_cnt_ff;
   logic              oq_push, oq_pop, do_put, wrap, rd_ok;
   logic [7:0]        put_ch;
   logic [COL_W:0]    col_nx;
   logic              we;
   logic [RAM_AW-1:0] waddr, raddr;
   logic [CELL_W-1:0] wdata, rdata;
   rsp_type           res;

   att_ram #(.WIDTH(CELL_W), .DEPTH(RAM_DEPTH)) u_cells (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   assign busy   = init_ff;
   assign empty  = (oq_cnt_ff == 2'd0);
   assign rsp    = oq_ff[oq_rp_ff];
   assign oq_pop = pop && !empty;
   assign col_nx = {1'b0, col_ff} + 1'b1;
   assign wrap   = (col_nx == (COL_W+1)'(COLUMNS));
   assign tab_nx = (tab_ff == TAB_W'(TAB_STOP - 1)) ? '0 : tab_ff + 1'b1;
   assign rd_ok  = (int'(cmd.row) < ROWS) && (int'(cmd.col) < COLUMNS);

   always_comb begin
      res.ch  = oob_ff ? 8'd0 : rdata[7:0];
      res.fg  = oob_ff ? 4'd0 : rdata[11:8];
      res.bg  = oob_ff ? 4'd0 : rdata[15:12];
      res.row = 5'(row_ff);
      res.col = 7'(col_ff);
   end

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      tab_in   = tab_ff;
      top_in   = top_ff;
      srow_in  = srow_ff;
      fg_in    = fg_ff;
      bg_in    = bg_ff;
      sweep_in = sweep_ff;
      init_in  = init_ff;
      oob_in   = oob_ff;
      cmd_pop  = 1'b0;
      oq_push  = 1'b0;
      do_put   = 1'b0;
      put_ch   = BYTE_SPACE;
      we       = 1'b0;
      waddr    = {phys_row(top_ff, row_ff), col_ff};
      wdata    = {bg_ff, fg_ff, BYTE_SPACE};
      raddr    = {phys_row(top_ff, ROW_W'(cmd.row)), COL_W'(cmd.col)};
      case (state_ff)
         B_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  CMD_PUT: begin
                     cmd_pop = 1'b1;
                     do_put  = 1'b1;
                     put_ch  = cmd.data;
                  end
                  CMD_TAB: begin
                     cmd_pop  = 1'b1;
                     state_in = B_TAB;
                  end
                  CMD_NEWLINE: begin
                     cmd_pop = 1'b1;
                  end
                  CMD_CLEAR: begin
                     cmd_pop  = 1'b1;
                     state_in = B_CLEAR;
                     sweep_in = '0;
                  end
                  CMD_COLOR: begin
                     cmd_pop = 1'b1;
                     fg_in   = cmd.fg;
                     bg_in   = cmd.bg;
                  end
                  CMD_READ: begin
                     if (oq_cnt_ff != 2'd2) begin
                        cmd_pop  = 1'b1;
                        oob_in   = !rd_ok;
                        state_in = B_READ;
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         B_TAB: begin
            do_put = 1'b1;
            if (!wrap && tab_nx == '0) begin
               state_in = B_IDLE;
            end
         end
         B_READ: begin
            oq_push  = 1'b1;
            state_in = B_IDLE;
         end
         B_SCROLL: begin
            we       = 1'b1;
            waddr    = {srow_ff, sweep_ff[COL_W-1:0]};
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff[COL_W-1:0] == COL_W'(COLUMNS - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_CLEAR: begin
            we       = 1'b1;
            waddr    = sweep_ff;
            sweep_in = sweep_ff + 1'b1;
            row_in   = '0;
            col_in   = '0;
            tab_in   = '0;
            top_in   = '0;
            if (sweep_ff == RAM_AW'(RAM_DEPTH - 1)) begin
               state_in = B_IDLE;
               init_in  = 1'b0;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      if (do_put) begin
         we     = 1'b1;
         wdata  = {bg_ff, fg_ff, put_ch};
         col_in = col_nx[COL_W-1:0];
         tab_in = tab_nx;
      end
      if ((do_put && wrap) || (cmd_pop && cmd.kind == CMD_NEWLINE)) begin
         col_in = '0;
         tab_in = '0;
         if (row_ff == ROW_W'(ROWS - 1)) begin
            top_in   = (top_ff == ROW_W'(ROWS - 1)) ? '0 : top_ff + 1'b1;
            srow_in  = top_ff;
            sweep_in = '0;
            state_in = B_SCROLL;
         end else begin
            row_in   = row_ff + 1'b1;
            state_in = B_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_CLEAR;
         sweep_ff  <= '0;
         init_ff   <= 1'b1;
         row_ff    <= '0;
         col_ff    <= '0;
         tab_ff    <= '0;
         top_ff    <= '0;
         fg_ff     <= FG_RESET;
         bg_ff     <= BG_RESET;
         oq_wp_ff  <= 1'b0;
         oq_rp_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         init_ff  <= init_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         tab_ff   <= tab_in;
         top_ff   <= top_in;
         fg_ff    <= fg_in;
         bg_ff    <= bg_in;
         if (oq_push) begin
            oq_wp_ff <= !oq_wp_ff;
         end
         if (oq_pop) begin
            oq_rp_ff <= !oq_rp_ff;
         end
         if (oq_push && !oq_pop) begin
            oq_cnt_ff <= oq_cnt_ff + 1'b1;
         end else if (!oq_push && oq_pop) begin
            oq_cnt_ff <= oq_cnt_ff - 1'b1;
         end
      end
      srow_ff <= srow_in;
      oob_ff  <= oob_in;
      if (oq_push) begin
         oq_ff[oq_wp_ff] <= res;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/att_checker.sv @@
// ----------------------------------------------------------------------------
// att_checker
// Port-level checks of the text terminal, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ansi_text_terminal_assert.svh"
module att_checker
   import att_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       push,
   input wire logic       full,
   input wire logic       req_operation,
   input wire logic [7:0] req_text_byte,
   input wire logic [4:0] req_read_row,
   input wire logic [6:0] req_read_column,
   input wire logic       empty,
   input wire logic       pop,
   input wire logic [7:0] rsp_cell_character,
   input wire logic [3:0] rsp_cell_foreground,
   input wire logic [3:0] rsp_cell_background,
   input wire logic [4:0] rsp_cursor_row_out,
   input wire logic [6:0] rsp_cursor_column_out
);

   `ATT_ASSERT_NEXT(a_reset_state, clock, 1'b0, reset, empty && full)

   `ATT_ASSERT_IMP(a_cursor_range, clock, reset, !empty, (int'(rsp_cursor_row_out) < ROWS) && (int'(rsp_cursor_column_out) < COLUMNS))

   `ATT_ASSERT_NEXT(a_word_held, clock, reset, !empty && !pop, !empty && $stable(rsp_cell_character) && $stable(rsp_cell_foreground) && $stable(rsp_cell_background) && $stable(rsp_cursor_row_out) && $stable(rsp_cursor_column_out))

endmodule

bind ansi_text_terminal att_checker u_att_checker (.*);
`default_nettype wire
